@@ rtl/core/owbm_pkg.sv @@
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes and slot timings shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned UsWidth     = 9;
  localparam int unsigned DivWidth    = 8;
  localparam int unsigned BitsWidth   = 4;

  typedef logic [ActionWidth-1:0] action_t;
  typedef logic [DataWidth-1:0]   data_t;
  typedef logic [UsWidth-1:0]     us_t;
  typedef logic [DivWidth-1:0]    div_t;
  typedef logic [BitsWidth-1:0]   bits_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOW,
    PH_WAIT,
    PH_RECOVER
  } phase_t;

  localparam action_t ACT_TICK  = 3'd0;
  localparam action_t ACT_RESET = 3'd1;
  localparam action_t ACT_WBIT  = 3'd2;
  localparam action_t ACT_RBIT  = 3'd3;
  localparam action_t ACT_WBYTE = 3'd4;
  localparam action_t ACT_RBYTE = 3'd5;

  localparam us_t RESET_LOW_US     = 9'd480;
  localparam us_t RESET_WAIT_US    = 9'd70;
  localparam us_t RESET_RECOVER_US = 9'd410;
  localparam us_t WRITE0_LOW_US    = 9'd60;
  localparam us_t WRITE0_REC_US    = 9'd10;
  localparam us_t SHORT_LOW_US     = 9'd6;
  localparam us_t WRITE1_REC_US    = 9'd64;
  localparam us_t READ_WAIT_US     = 9'd9;
  localparam us_t READ_REC_US      = 9'd55;

  localparam bits_t BITS_ONE  = 4'd1;
  localparam bits_t BITS_BYTE = 4'd8;

  localparam div_t TICKS_PER_US_RESET = 8'd1;

  // Length of the low phase that opens a slot.
  function automatic us_t slot_low_us(action_t op, logic lsb);
    us_t d;
    if (op == ACT_RESET) begin
      d = RESET_LOW_US;
    end else if (op == ACT_RBIT || op == ACT_RBYTE) begin
      d = SHORT_LOW_US;
    end else begin
      d = lsb ? SHORT_LOW_US : WRITE0_LOW_US;
    end
    return d;
  endfunction

endpackage

@@ rtl/core/one_wire_bus_master.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one input item per clock tick unless stalled.
// ----------------------------------------------------------------------------
// Each input item is one tick of bus time: an action code (tick only, bus
// reset, write bit, read bit, write byte, read byte), the byte to write and
// the sampled bus level. A command is taken only while idle; one that arrives
// during an operation is ignored and flagged by rejected. Every input item
// gives exactly one result item holding the bus drive, busy, done, presence,
// the last read data and the reject flag, all as of the end of that tick.
// The cfg channel writes ticks_per_us, the prescaler that turns ticks into
// microseconds of slot timing; write it only while the block is idle.
// One item is accepted per cycle unless stalled; its registered result
// shows in the next cycle. The next state is computed by one pass of logic
// from the state registers and the accepted item. in_stall is raised only
// while a result is held and out_stall is high, so a stalled receiver
// holds the input side for as long as it stalls. Synchronous reset returns
// the block to idle with ticks_per_us at 1 and empties the output register.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  owbm_pkg::div_t   cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  owbm_pkg::action_t action,
  input  owbm_pkg::data_t  data_in,
  input  logic             bus_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             drive_low,
  output logic             busy_res,
  output logic             done_res,
  output logic             presence,
  output owbm_pkg::data_t  read_data,
  output logic             rejected
);
  import owbm_pkg::*;

  div_t    ticks_per_us;
  phase_t  phase, phase_next;
  action_t operation, operation_next;
  us_t     us_timer, us_timer_next;
  div_t    prescale_count, prescale_count_next;
  bits_t   bits_left, bits_left_next;
  data_t   shift_reg, shift_reg_next;
  logic    presence_flag, presence_flag_next;
  data_t   last_read, last_read_next;

  logic    done_next, rejected_next;
  logic    drive_low_next, busy_next;
  logic    in_accept;
  logic    cmd;
  logic    is_wr, is_rd;
  div_t    div;
  data_t   sr_adv;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    phase_next          = phase;
    operation_next      = operation;
    us_timer_next       = us_timer;
    prescale_count_next = prescale_count;
    bits_left_next      = bits_left;
    shift_reg_next      = shift_reg;
    presence_flag_next  = presence_flag;
    last_read_next      = last_read;
    done_next           = 1'b0;
    rejected_next       = 1'b0;
    cmd    = action inside {[ACT_RESET:ACT_RBYTE]};
    is_wr  = (operation == ACT_WBIT) || (operation == ACT_WBYTE);
    is_rd  = (operation == ACT_RBIT) || (operation == ACT_RBYTE);
    div    = (ticks_per_us == '0) ? TICKS_PER_US_RESET : ticks_per_us;
    sr_adv = is_wr ? (shift_reg >> 1) : shift_reg;

    if (phase == PH_IDLE) begin
      if (cmd) begin
        operation_next = action;
        case (action)
          ACT_WBIT: begin
            shift_reg_next = {{(DataWidth-1){1'b0}}, data_in[0]};
            bits_left_next = BITS_ONE;
          end
          ACT_WBYTE: begin
            shift_reg_next = data_in;
            bits_left_next = BITS_BYTE;
          end
          ACT_RBYTE: begin
            shift_reg_next = '0;
            bits_left_next = BITS_BYTE;
          end
          default: begin
            shift_reg_next = '0;
            bits_left_next = BITS_ONE;
          end
        endcase
        phase_next          = PH_LOW;
        us_timer_next       = slot_low_us(action, shift_reg_next[0]);
        prescale_count_next = '0;
      end
    end else begin
      rejected_next = cmd;
      if ({1'b0, prescale_count} + 9'd1 >= {1'b0, div}) begin
        prescale_count_next = '0;
        if (us_timer <= us_t'(1)) begin
          us_timer_next = '0;
          case (phase)
            PH_LOW: begin
              if (operation == ACT_RESET) begin
                phase_next    = PH_WAIT;
                us_timer_next = RESET_WAIT_US;
              end else if (is_rd) begin
                phase_next    = PH_WAIT;
                us_timer_next = READ_WAIT_US;
              end else begin
                phase_next    = PH_RECOVER;
                us_timer_next = shift_reg[0] ? WRITE1_REC_US : WRITE0_REC_US;
              end
            end
            PH_WAIT: begin
              phase_next = PH_RECOVER;
              if (operation == ACT_RESET) begin
                presence_flag_next = ~bus_level;
                us_timer_next      = RESET_RECOVER_US;
              end else begin
                shift_reg_next = {bus_level, shift_reg[DataWidth-1:1]};
                us_timer_next  = READ_REC_US;
              end
            end
            default: begin
              if (bits_left > BITS_ONE) begin
                bits_left_next = bits_left - BITS_ONE;
                shift_reg_next = sr_adv;
                phase_next     = PH_LOW;
                us_timer_next  = slot_low_us(operation, sr_adv[0]);
              end else begin
                if (operation == ACT_RBIT) begin
                  last_read_next = {{(DataWidth-1){1'b0}}, shift_reg[DataWidth-1]};
                end else if (operation == ACT_RBYTE) begin
                  last_read_next = shift_reg;
                end
                phase_next     = PH_IDLE;
                bits_left_next = '0;
                done_next      = 1'b1;
              end
            end
          endcase
        end else begin
          us_timer_next = us_timer - us_t'(1);
        end
      end else begin
        prescale_count_next = prescale_count + div_t'(1);
      end
    end
  end

  always_comb begin
    drive_low_next = (phase_next == PH_LOW);
    busy_next      = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_PER_US_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_us <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      operation      <= ACT_TICK;
      us_timer       <= '0;
      prescale_count <= '0;
      bits_left      <= '0;
      shift_reg      <= '0;
      presence_flag  <= 1'b0;
      last_read      <= '0;
    end else if (in_accept) begin
      phase          <= phase_next;
      operation      <= operation_next;
      us_timer       <= us_timer_next;
      prescale_count <= prescale_count_next;
      bits_left      <= bits_left_next;
      shift_reg      <= shift_reg_next;
      presence_flag  <= presence_flag_next;
      last_read      <= last_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low <= drive_low_next;
      busy_res  <= busy_next;
      done_res  <= done_next;
      presence  <= presence_flag_next;
      read_data <= last_read_next;
      rejected  <= rejected_next;
    end
  end

endmodule

@@ tb/one_wire_bus_master_checker.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// Watches the channels of the 1-Wire bus master, predicts and compares.
// ----------------------------------------------------------------------------
// Every accepted input item is run through a cycle-level copy of the bus
// master timing (prescaler, slot phases, bit shifting, presence and read
// capture). The bus status it predicts is queued. Every accepted result item
// is compared field by field with the oldest queued status. The divider copy
// follows the accepted writes on the cfg channel.
// ----------------------------------------------------------------------------
module one_wire_bus_master_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  owbm_pkg::div_t    cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  owbm_pkg::action_t action,
  input  owbm_pkg::data_t   data_in,
  input  logic              bus_level,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              drive_low,
  input  logic              busy_res,
  input  logic              done_res,
  input  logic              presence,
  input  owbm_pkg::data_t   read_data,
  input  logic              rejected,
  output int unsigned       error_count,
  output int unsigned       pending_items
);
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  typedef struct packed {
    logic  drive;
    logic  busy;
    logic  done;
    logic  pres;
    data_t rdata;
    logic  rej;
  } bus_status_t;

  bus_status_t status_q[$];
  bus_status_t predicted;
  int unsigned fail_tally = 0;

  phase_t  cur_phase     = PH_IDLE;
  action_t cur_op        = ACT_TICK;
  us_t     us_left       = '0;
  div_t    prescale      = '0;
  bits_t   bits_left     = '0;
  data_t   shifter       = '0;
  logic    presence_seen = 1'b0;
  data_t   last_read     = '0;
  div_t    divider       = TICKS_PER_US_RESET;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  task automatic set_phase(input phase_t p, input us_t len);
    cur_phase = p;
    us_left   = len;
    prescale  = '0;
  endtask

  task automatic open_slot();
    if (cur_op == ACT_RESET) begin
      set_phase(PH_LOW, RESET_LOW_US);
    end else if (cur_op == ACT_RBIT || cur_op == ACT_RBYTE) begin
      set_phase(PH_LOW, SHORT_LOW_US);
    end else begin
      set_phase(PH_LOW, shifter[0] ? SHORT_LOW_US : WRITE0_LOW_US);
    end
  endtask

  task automatic close_interval(input logic lvl, output logic fin);
    fin = 1'b0;
    case (cur_phase)
      PH_LOW: begin
        if (cur_op == ACT_RESET) begin
          set_phase(PH_WAIT, RESET_WAIT_US);
        end else if (cur_op == ACT_RBIT || cur_op == ACT_RBYTE) begin
          set_phase(PH_WAIT, READ_WAIT_US);
        end else begin
          set_phase(PH_RECOVER, shifter[0] ? WRITE1_REC_US : WRITE0_REC_US);
        end
      end
      PH_WAIT: begin
        if (cur_op == ACT_RESET) begin
          presence_seen = ~lvl;
          set_phase(PH_RECOVER, RESET_RECOVER_US);
        end else begin
          shifter = {lvl, shifter[7:1]};
          set_phase(PH_RECOVER, READ_REC_US);
        end
      end
      default: begin
        if (bits_left > BITS_ONE) begin
          bits_left = bits_left - 1'b1;
          if (cur_op == ACT_WBIT || cur_op == ACT_WBYTE) begin
            shifter = shifter >> 1;
          end
          open_slot();
        end else begin
          if (cur_op == ACT_RBIT) begin
            last_read = {7'd0, shifter[7]};
          end else if (cur_op == ACT_RBYTE) begin
            last_read = shifter;
          end
          cur_phase = PH_IDLE;
          bits_left = '0;
          us_left   = '0;
          prescale  = '0;
          fin       = 1'b1;
        end
      end
    endcase
  endtask

  task automatic step_master(input action_t a, input data_t d, input logic lvl,
                             output bus_status_t st);
    logic is_cmd;
    logic rej;
    logic fin;
    int unsigned div_eff;
    is_cmd = (a >= ACT_RESET) && (a <= ACT_RBYTE);
    rej = 1'b0;
    fin = 1'b0;
    if (cur_phase == PH_IDLE) begin
      if (is_cmd) begin
        cur_op = a;
        case (a)
          ACT_WBIT: begin
            shifter   = {7'd0, d[0]};
            bits_left = BITS_ONE;
          end
          ACT_WBYTE: begin
            shifter   = d;
            bits_left = BITS_BYTE;
          end
          ACT_RBYTE: begin
            shifter   = '0;
            bits_left = BITS_BYTE;
          end
          default: begin
            shifter   = '0;
            bits_left = BITS_ONE;
          end
        endcase
        open_slot();
      end
    end else begin
      div_eff = (divider == 0) ? 1 : divider;
      rej = is_cmd;
      if (int'(prescale) + 1 >= div_eff) begin
        prescale = '0;
        if (us_left <= 1) begin
          us_left = '0;
          close_interval(lvl, fin);
        end else begin
          us_left = us_left - 1'b1;
        end
      end else begin
        prescale = prescale + 1'b1;
      end
    end
    st.drive = (cur_phase == PH_LOW);
    st.busy  = (cur_phase != PH_IDLE);
    st.done  = fin;
    st.pres  = presence_seen;
    st.rdata = last_read;
    st.rej   = rej;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_phase     = PH_IDLE;
      cur_op        = ACT_TICK;
      us_left       = '0;
      prescale      = '0;
      bits_left     = '0;
      shifter       = '0;
      presence_seen = 1'b0;
      last_read     = '0;
      divider       = TICKS_PER_US_RESET;
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("result item with no prediction waiting");
        end else begin
          predicted = status_q.pop_front();
          check_field("drive_low", drive_low, predicted.drive);
          check_field("busy_res", busy_res, predicted.busy);
          check_field("done_res", done_res, predicted.done);
          check_field("presence", presence, predicted.pres);
          check_field("read_data", read_data, predicted.rdata);
          check_field("rejected", rejected, predicted.rej);
        end
      end
      if (cfg_valid && cfg_ready) begin
        divider = cfg_data;
      end
      if (in_valid && !in_stall) begin
        step_master(action, data_in, bus_level, predicted);
        status_q.push_back(predicted);
      end
    end
    error_count   <= fail_tally;
    pending_items <= status_q.size();
  end

endmodule

@@ tb/one_wire_bus_master_tb.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Stimulus and verdict for the 1-Wire bus master.
// ----------------------------------------------------------------------------
// Drives bit commands and a bus reset tick by tick, with rejected commands
// and spare action codes mixed in while an operation runs, under several
// prescaler settings and idling patterns on both channels. The checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned NO_CAP       = 100_000;
  localparam int unsigned RESET_CAP    = 580;
  localparam action_t     ACT_SPARE_LO = 3'd6;
  localparam action_t     ACT_SPARE_HI = 3'd7;
  localparam int          LEVEL_LOW    = 0;
  localparam int          LEVEL_HIGH   = 1;
  localparam int          LEVEL_RANDOM = 2;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  div_t    cfg_data  = '0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  action_t action    = ACT_TICK;
  data_t   data_in   = '0;
  logic    bus_level = 1'b1;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    drive_low;
  logic    busy_res;
  logic    done_res;
  logic    presence;
  data_t   read_data;
  logic    rejected;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned done_seen     = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned error_count;
  int unsigned pending_items;

  one_wire_bus_master u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .data_in   (data_in),
    .bus_level (bus_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_low (drive_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .presence  (presence),
    .read_data (read_data),
    .rejected  (rejected)
  );

  one_wire_bus_master_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .data_in       (data_in),
    .bus_level     (bus_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_low     (drive_low),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .presence      (presence),
    .read_data     (read_data),
    .rejected      (rejected),
    .error_count   (error_count),
    .pending_items (pending_items)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall && done_res) begin
      done_seen <= done_seen + 1;
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("one_wire_bus_master_tb: errors");
      $finish;
    end
  end

  task automatic push_tick(input action_t a, input data_t d, input logic lvl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    action    <= a;
    data_in   <= d;
    bus_level <= lvl;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Commands mixed in during the first 60 ticks always hit a busy block,
  // since no operation is shorter than 70 microseconds.
  task automatic run_operation(input action_t a, input data_t d, input int lvl_mode,
                               input int unsigned noise_pct,
                               input int unsigned max_items);
    int unsigned mark;
    int unsigned n;
    action_t     act;
    logic        lvl;
    mark = done_seen;
    n = 0;
    while (done_seen == mark && n < max_items) begin
      if (lvl_mode == LEVEL_RANDOM) begin
        lvl = ($urandom_range(1) != 0);
      end else begin
        lvl = (lvl_mode == LEVEL_HIGH);
      end
      if (n == 0) begin
        act = a;
      end else if (n < 60 && $urandom_range(99) < noise_pct) begin
        act = action_t'($urandom_range(ACT_RBYTE, ACT_RESET));
      end else if ($urandom_range(99) < 3) begin
        act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end else begin
        act = ACT_TICK;
      end
      push_tick(act, (n == 0) ? d : data_t'($urandom_range(255)), lvl);
      n++;
    end
  endtask

  task automatic write_divider(input div_t v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_items != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 56;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_divider(TICKS_PER_US_RESET);

    push_tick(ACT_TICK, 8'h00, 1'b1);
    push_tick(ACT_SPARE_LO, 8'hFF, 1'b0);
    push_tick(ACT_SPARE_HI, 8'h5A, 1'b1);
    run_operation(ACT_WBIT, 8'hFE, LEVEL_RANDOM, 20, NO_CAP);
    run_operation(ACT_RBIT, 8'hFF, LEVEL_HIGH, 20, NO_CAP);
    run_operation(ACT_RBIT, 8'h00, LEVEL_LOW, 20, NO_CAP);

    send_idle_pct = 56;
    recv_idle_pct = 30;
    write_divider(8'd2);
    run_operation(ACT_WBIT, 8'h01, LEVEL_RANDOM, 20, NO_CAP);
    push_tick(ACT_SPARE_HI, 8'h00, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_divider(8'd0);
    run_operation(ACT_RESET, 8'h00, LEVEL_LOW, 20, RESET_CAP);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_items != 0);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("one_wire_bus_master_tb: clean");
    end else begin
      $display("one_wire_bus_master_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/owbm_pkg.sv
rtl/core/one_wire_bus_master.sv
tb/one_wire_bus_master_checker.sv
tb/one_wire_bus_master_tb.sv
